// ===== rtl/cvkp_pkg.sv =====
// package for the constant-velocity kalman predict block
// holds fixed-point constants, controller states and noise selection codes
// no dependencies
package cvkp_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int TS_FRAC    = 12;
	localparam int SIGMA_FRAC = 8;
	localparam int N_ELEM     = 20;
	localparam int ADDR_W     = 5;

	localparam logic [15:0] SIGMA_RESET = 16'd256;

	// rounding shifts that bring ts^2, ts^3/2 and ts^4/4 to FRAC_BITS
	localparam int SH_T2 = 2 * TS_FRAC - FRAC_BITS;
	localparam int SH_T3 = 3 * TS_FRAC + 1 - FRAC_BITS;
	localparam int SH_T4 = 4 * TS_FRAC + 2 - FRAC_BITS;

	// width of one noise entry after the sigma^2 scaling
	localparam int Q_W = 47;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NOISE,
		ST_EL_RD,
		ST_EL_MUL,
		ST_EL_ACC,
		ST_EL_WB,
		ST_OUT
	} state_t;

	// operand terms summed for one element
	typedef enum logic [1:0] {
		OP_SELF,
		OP_ROW,
		OP_COL,
		OP_DIAG
	} op_t;

	typedef enum logic [1:0] {
		NQ_NONE,
		NQ_T2,
		NQ_T3,
		NQ_T4
	} noise_sel_t;

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_PREDICT = 1'b1;

	// noise entry that goes with each covariance element, row-major
	function automatic noise_sel_t noise_sel(input logic [3:0] c);
		noise_sel_t s;
		s = NQ_NONE;
		unique case (c)
			4'd0, 4'd5:               s = NQ_T4;
			4'd2, 4'd7, 4'd8, 4'd13:  s = NQ_T3;
			4'd10, 4'd15:             s = NQ_T2;
			default:                  s = NQ_NONE;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/cv_kalman_predict_top.sv =====
// constant-velocity 2d kalman prediction step, state held in one memory; uses cvkp_pkg
// a predict transfer first runs the noise states, then for each element a read, multiply
// and accumulate state per summed term and a write-back state before its result; a load
// gives no result; one item at a time: a predict keeps the input stalled until its last
// result is taken, paced by the single shared multiplier and the single memory read port
// reset clears the controller and the entry valid bits (all state reads zero), sigma is 1.0
module cv_kalman_predict_top
	import cvkp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [4:0]         elem_index,
	input  logic signed [31:0] elem_value,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         out_index,
	output logic signed [31:0] out_value,
	output logic               out_last
);

	state_t state_q, state_d;

	logic [15:0] sigma_q;
	logic [15:0] ts_q;
	logic [2:0]  n_q;
	logic [4:0]  e_q;
	op_t         k_q, k_d;
	logic        el_done;

	logic [31:0] t2_q;
	logic [47:0] t3_q;
	logic [63:0] t4_q;
	logic [31:0] s2_q;
	logic [Q_W-1:0] q2_q, q3_q, q4_q;

	logic signed [63:0] acc_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;

	// state memory: 4 mean entries then 16 covariance entries
	logic signed [31:0] mem [N_ELEM];
	logic [N_ELEM-1:0]  vld_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic signed [31:0] rd_data_q;
	logic               rd_vld_q;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic signed [31:0] wr_data;

	logic in_xfer, out_xfer;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_xfer  = out_valid && !out_stall;

	// element geometry
	logic       is_mean;
	logic [3:0] cidx;
	logic       en_row, en_col, en_diag;

	assign is_mean = (e_q < 5'd4);
	assign cidx    = 4'(e_q - 5'd4);
	assign en_row  = is_mean ? (e_q < 5'd2) : !cidx[3];
	assign en_col  = !is_mean && !cidx[1];
	assign en_diag = !is_mean && !cidx[3] && !cidx[1];

	// read address of the current term
	always_comb begin
		rd_addr = e_q;
		case (k_q)
			OP_SELF: rd_addr = e_q;
			OP_ROW:  rd_addr = is_mean ? 5'(e_q + 5'd2) : 5'(e_q + 5'd8);
			OP_COL:  rd_addr = 5'(e_q + 5'd2);
			OP_DIAG: rd_addr = 5'(e_q + 5'd10);
			default: rd_addr = e_q;
		endcase
	end

	// next enabled term after the current one
	always_comb begin
		k_d     = k_q;
		el_done = 1'b0;
		if (k_q == OP_SELF && en_row) begin
			k_d = OP_ROW;
		end else if ((k_q == OP_SELF || k_q == OP_ROW) && en_col) begin
			k_d = OP_COL;
		end else if (k_q != OP_DIAG && en_diag) begin
			k_d = OP_DIAG;
		end else begin
			el_done = 1'b1;
		end
	end

	// rounded noise arguments
	logic [64:0] a2_w, a3_w, a4_w;
	logic [31:0] a2, a3, a4;

	assign a2_w = (65'(t2_q) + (65'd1 << (SH_T2 - 1))) >> SH_T2;
	assign a3_w = (65'(t3_q) + (65'd1 << (SH_T3 - 1))) >> SH_T3;
	assign a4_w = (65'(t4_q) + (65'd1 << (SH_T4 - 1))) >> SH_T4;
	assign a2   = a2_w[31:0];
	assign a3   = a3_w[31:0];
	assign a4   = a4_w[31:0];

	// sigma^2 scaling of one noise argument, clamped on overflow
	logic [63:0]    p_u;
	logic [64:0]    p_rnd;
	logic [Q_W-1:0] q_new;

	assign p_u   = prod_q[63:0];
	assign p_rnd = (65'(p_u) + (65'd1 << (2 * SIGMA_FRAC - 1))) >> (2 * SIGMA_FRAC);
	assign q_new = (p_u > (64'd1 << 62)) ? (Q_W'(1) << 46) : p_rnd[Q_W-1:0];

	// shared multiplier operands
	logic signed [31:0] rd_d;
	assign rd_d = rd_vld_q ? rd_data_q : 32'sd0;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_NOISE) begin
			case (n_q)
				3'd0: begin mul_a = 33'(ts_q);    mul_b = 33'(ts_q); end
				3'd1: begin mul_a = 33'(sigma_q); mul_b = 33'(sigma_q); end
				3'd2: begin mul_a = 33'(t2_q);    mul_b = 33'(ts_q); end
				3'd3: begin mul_a = 33'(t2_q);    mul_b = 33'(t2_q); end
				3'd4: begin mul_a = 33'(s2_q);    mul_b = 33'(a2); end
				3'd5: begin mul_a = 33'(s2_q);    mul_b = 33'(a3); end
				3'd6: begin mul_a = 33'(s2_q);    mul_b = 33'(a4); end
				default: begin mul_a = '0;        mul_b = '0; end
			endcase
		end else begin
			mul_a = 33'(rd_d);
			case (k_q)
				OP_SELF: mul_b = 33'(1) <<< TS_FRAC;
				OP_ROW:  mul_b = 33'(ts_q);
				OP_COL:  mul_b = 33'(ts_q);
				OP_DIAG: mul_b = 33'(t2_q);
				default: mul_b = '0;
			endcase
		end
	end

	// term added in the accumulate step
	logic signed [63:0] term;
	assign term = (k_q == OP_DIAG) ? 64'(prod_q >>> TS_FRAC) : prod_q[63:0];

	// final rounding and saturation of one element
	logic [Q_W-1:0]     q_el;
	logic signed [63:0] sum_w, res_w;
	logic signed [31:0] res_sat;

	always_comb begin
		q_el = '0;
		if (!is_mean) begin
			case (noise_sel(cidx))
				NQ_T2:   q_el = q2_q;
				NQ_T3:   q_el = q3_q;
				NQ_T4:   q_el = q4_q;
				default: q_el = '0;
			endcase
		end
		sum_w = acc_q + (64'(q_el) <<< TS_FRAC) + (64'sd1 <<< (TS_FRAC - 1));
		res_w = sum_w >>> TS_FRAC;
		if (res_w > 64'sd2147483647) begin
			res_sat = 32'sh7FFFFFFF;
		end else if (res_w < -64'sd2147483648) begin
			res_sat = 32'sh80000000;
		end else begin
			res_sat = res_w[31:0];
		end
	end

	// memory write: load transfer or element write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = elem_index;
		wr_data = elem_value;
		if (in_xfer && req_type == REQ_LOAD && elem_index < 5'(N_ELEM)) begin
			wr_en = 1'b1;
		end else if (state_q == ST_EL_WB) begin
			wr_en   = 1'b1;
			wr_addr = e_q;
			wr_data = res_sat;
		end
	end

	// state memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// entry valid bits, unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	// sigma register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
		end else if (cfg_wr_en) begin
			sigma_q <= cfg_wr_data;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_xfer && req_type == REQ_PREDICT) state_d = ST_NOISE;
			ST_NOISE:  if (n_q == 3'd7) state_d = ST_EL_RD;
			ST_EL_RD:  state_d = ST_EL_MUL;
			ST_EL_MUL: state_d = ST_EL_ACC;
			ST_EL_ACC: state_d = el_done ? ST_EL_WB : ST_EL_RD;
			ST_EL_WB:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_xfer) begin
					state_d = (e_q == 5'(N_ELEM - 1)) ? ST_IDLE : ST_EL_RD;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			e_q <= '0;
			k_q <= OP_SELF;
		end else begin
			case (state_q)
				ST_IDLE: begin
					n_q <= '0;
					e_q <= '0;
					k_q <= OP_SELF;
				end
				ST_NOISE:  n_q <= 3'(n_q + 3'd1);
				ST_EL_ACC: k_q <= el_done ? OP_SELF : k_d;
				ST_OUT: begin
					if (out_xfer) begin
						e_q <= 5'(e_q + 5'd1);
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_xfer) begin
			ts_q <= time_step;
		end
		if (state_q == ST_NOISE) begin
			case (n_q)
				3'd1: t2_q <= prod_q[31:0];
				3'd2: s2_q <= prod_q[31:0];
				3'd3: t3_q <= prod_q[47:0];
				3'd4: t4_q <= prod_q[63:0];
				3'd5: q2_q <= q_new;
				3'd6: q3_q <= q_new;
				3'd7: q4_q <= q_new;
				default: ;
			endcase
		end
		if (state_q == ST_EL_ACC) begin
			acc_q <= (k_q == OP_SELF) ? term : acc_q + term;
		end
		if (state_q == ST_EL_WB) begin
			out_index <= e_q;
			out_value <= res_sat;
			out_last  <= (e_q == 5'(N_ELEM - 1));
		end
	end

endmodule
